// ===== hdl/kbp_pkg.sv =====
package kbp_pkg;

  localparam int COORD_IN_BITS   = 20;
  localparam int SIZE_FIELD_BITS = 10;
  localparam int DIM_BITS        = 16;
  localparam int CFG_INDEX_BITS  = 1;
  localparam int BYTE_BITS       = 8;

  // Rounded coordinate, field widths and packed word
  localparam int ROUND_BITS      = COORD_IN_BITS - 1;
  localparam int FIELD_MAX_BITS  = DIM_BITS + 2;
  localparam int FW_BITS         = $clog2(FIELD_MAX_BITS + 1);
  localparam int YS_BITS         = FIELD_MAX_BITS + SIZE_FIELD_BITS;
  localparam int WORD_BITS       = FIELD_MAX_BITS + YS_BITS;
  localparam int LEN_BITS        = $clog2(WORD_BITS + 1);

  // Back end accumulator
  localparam int PEND_BITS       = BYTE_BITS - 1;
  localparam int PCNT_BITS       = $clog2(BYTE_BITS);
  localparam int ACC_BITS        = ((PEND_BITS + WORD_BITS + BYTE_BITS - 1) / BYTE_BITS)
                                   * BYTE_BITS;
  localparam int CNT_BITS        = $clog2(ACC_BITS + 1);

  // Queue between front and back
  localparam int QUEUE_DEPTH     = 2;
  localparam int QPTR_BITS       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH  = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = CFG_INDEX_BITS'(1);

  localparam logic [DIM_BITS-1:0] IMAGE_WIDTH_RESET  = DIM_BITS'(640);
  localparam logic [DIM_BITS-1:0] IMAGE_HEIGHT_RESET = DIM_BITS'(480);

  localparam logic MODE_PACK   = 1'b0;
  localparam logic MODE_FINISH = 1'b1;

  typedef struct packed {
    logic                 mode;
    logic [WORD_BITS-1:0] word;  // fields left aligned, unused low bits zero
    logic [LEN_BITS-1:0]  len;
  } kbp_entry_t;

  typedef struct packed {
    logic                busy;
    logic [CNT_BITS-1:0] cnt;
  } kbp_status_t;

  // Field width: ceil(log2(dim)) + 2, a zero dimension counts as one
  function automatic logic [FW_BITS-1:0] field_bits(input logic [DIM_BITS-1:0] dim);
    logic [DIM_BITS-1:0] d;
    logic [FW_BITS-1:0]  k;
    d = (dim == '0) ? '0 : dim - DIM_BITS'(1);
    k = '0;
    for (int i = 0; i < DIM_BITS; i++) begin
      if (d[i]) k = FW_BITS'(i + 1);
    end
    return k + FW_BITS'(2);
  endfunction

  // Round to quarter units, half up
  function automatic logic [ROUND_BITS-1:0] round_quarter(
    input logic [COORD_IN_BITS-1:0] v
  );
    logic [COORD_IN_BITS:0] sum;
    sum = {1'b0, v} + (COORD_IN_BITS + 1)'(2);
    return sum[COORD_IN_BITS:2];
  endfunction

endpackage

// ===== hdl/kbp_if.sv =====
interface kbp_in_if;
  import kbp_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     mode;
  logic [COORD_IN_BITS-1:0] x_pos;
  logic [COORD_IN_BITS-1:0] y_pos;
  logic [COORD_IN_BITS-1:0] kp_size;

  modport source (output valid, mode, x_pos, y_pos, kp_size, input ready);
  modport sink   (input valid, mode, x_pos, y_pos, kp_size, output ready);
endinterface

interface kbp_out_if;
  import kbp_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [BYTE_BITS-1:0] packed_byte;
  logic                 last_of_run;

  modport source (output valid, packed_byte, last_of_run, input ready);
  modport sink   (input valid, packed_byte, last_of_run, output ready);
endinterface

// ===== hdl/kbp_front.sv =====
module kbp_front (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [kbp_pkg::CFG_INDEX_BITS-1:0]   cfg_index_i,
  input  logic [kbp_pkg::DIM_BITS-1:0]         cfg_wdata_i,
  kbp_in_if.sink                               kp_in_i,
  output logic                                 push_o,
  output kbp_pkg::kbp_entry_t                  push_entry_o,
  input  logic                                 full_i
);
  import kbp_pkg::*;

  logic [FW_BITS-1:0]        bx_q, bx_d, by_q, by_d;
  logic [ROUND_BITS-1:0]     qx, qy, qs;
  logic [FIELD_MAX_BITS-1:0] qx_l, qy_l;
  logic [YS_BITS-1:0]        ys;
  logic [WORD_BITS-1:0]      word;

  // Hold field widths, worked out once per register write
  always_comb begin
    bx_d = bx_q;
    by_d = by_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        REG_IMAGE_WIDTH:  bx_d = field_bits(cfg_wdata_i);
        REG_IMAGE_HEIGHT: by_d = field_bits(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bx_q <= field_bits(IMAGE_WIDTH_RESET);
      by_q <= field_bits(IMAGE_HEIGHT_RESET);
    end else begin
      bx_q <= bx_d;
      by_q <= by_d;
    end
  end

  // Round, drop bits above each field and left align the three fields
  always_comb begin
    qx   = round_quarter(kp_in_i.x_pos);
    qy   = round_quarter(kp_in_i.y_pos);
    qs   = round_quarter(kp_in_i.kp_size);
    qx_l = FIELD_MAX_BITS'(qx) << (FW_BITS'(FIELD_MAX_BITS) - bx_q);
    qy_l = FIELD_MAX_BITS'(qy) << (FW_BITS'(FIELD_MAX_BITS) - by_q);
    ys   = {qy_l, {SIZE_FIELD_BITS{1'b0}}}
         | ({qs[SIZE_FIELD_BITS-1:0], {FIELD_MAX_BITS{1'b0}}} >> by_q);
    word = {qx_l, {YS_BITS{1'b0}}} | ({ys, {FIELD_MAX_BITS{1'b0}}} >> bx_q);
  end

  always_comb begin
    push_entry_o.mode = kp_in_i.mode;
    if (kp_in_i.mode == MODE_FINISH) begin
      push_entry_o.word = '0;
      push_entry_o.len  = '0;
    end else begin
      push_entry_o.word = word;
      push_entry_o.len  = LEN_BITS'(bx_q) + LEN_BITS'(by_q) + LEN_BITS'(SIZE_FIELD_BITS);
    end
  end

  assign kp_in_i.ready = !full_i;
  assign push_o        = kp_in_i.valid && !full_i;

endmodule

// ===== hdl/kbp_queue.sv =====
module kbp_queue (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  kbp_pkg::kbp_entry_t           push_entry_i,
  input  logic                          pop_i,
  output kbp_pkg::kbp_entry_t           pop_entry_o,
  output logic                          pop_valid_o,
  output logic                          full_o,
  output logic [kbp_pkg::QCNT_BITS-1:0] count_o
);
  import kbp_pkg::*;

  kbp_entry_t           slot_q [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_BITS-1:0] count_q;
  logic                 do_push, do_pop;

  assign full_o      = (count_q == QCNT_BITS'(QUEUE_DEPTH));
  assign pop_valid_o = (count_q != '0);
  assign pop_entry_o = slot_q[rd_ptr_q];
  assign count_o     = count_q;
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_i && pop_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wr_ptr_q] <= push_entry_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                               : wr_ptr_q + QPTR_BITS'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                               : rd_ptr_q + QPTR_BITS'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + QCNT_BITS'(1);
        2'b01:   count_q <= count_q - QCNT_BITS'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ===== hdl/kbp_back.sv =====
module kbp_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  kbp_pkg::kbp_entry_t   entry_i,
  input  logic                  entry_valid_i,
  output logic                  pop_o,
  kbp_out_if.source             byte_out_o,
  output kbp_pkg::kbp_status_t  status_o
);
  import kbp_pkg::*;

  logic [ACC_BITS-1:0]  sh_q, sh_new, shifted;
  logic [CNT_BITS-1:0]  cnt_q, cnt_new;
  logic                 busy_q;
  logic [PEND_BITS-1:0] pend_q, pend_c;
  logic [PCNT_BITS-1:0] pcnt_q, pcnt_c;
  logic                 ov_q;
  logic [BYTE_BITS-1:0] byte_q;
  logic                 last_q;
  logic                 fire, last, load;

  // Emit one byte a cycle while the output register is free or drained
  assign fire    = busy_q && (!ov_q || byte_out_o.ready);
  assign last    = (cnt_q < CNT_BITS'(2 * BYTE_BITS));
  assign shifted = sh_q << BYTE_BITS;
  assign load    = (!busy_q || (fire && last)) && entry_valid_i;
  assign pop_o   = load;

  // Leftover bits as they stand after this cycle's byte, left aligned
  always_comb begin
    if (fire && last) begin
      pend_c = shifted[ACC_BITS-1 -: PEND_BITS];
      pcnt_c = cnt_q[PCNT_BITS-1:0];
    end else begin
      pend_c = pend_q;
      pcnt_c = pcnt_q;
    end
  end

  always_comb begin
    sh_new = {pend_c, {(ACC_BITS - PEND_BITS){1'b0}}};
    if (entry_i.mode == MODE_FINISH) begin
      cnt_new = (pcnt_c != '0) ? CNT_BITS'(BYTE_BITS) : '0;
    end else begin
      sh_new  = sh_new
              | ({entry_i.word, {(ACC_BITS - WORD_BITS){1'b0}}} >> pcnt_c);
      cnt_new = CNT_BITS'(pcnt_c) + CNT_BITS'(entry_i.len);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      pend_q <= '0;
      pcnt_q <= '0;
      ov_q   <= 1'b0;
    end else begin
      if (load) begin
        busy_q <= (cnt_new >= CNT_BITS'(BYTE_BITS));
        cnt_q  <= cnt_new;
        pend_q <= sh_new[ACC_BITS-1 -: PEND_BITS];
        pcnt_q <= cnt_new[PCNT_BITS-1:0];
      end else if (fire) begin
        cnt_q <= cnt_q - CNT_BITS'(BYTE_BITS);
        if (last) begin
          busy_q <= 1'b0;
          pend_q <= pend_c;
          pcnt_q <= pcnt_c;
        end
      end
      if (fire) begin
        ov_q <= 1'b1;
      end else if (byte_out_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      sh_q <= sh_new;
    end else if (fire) begin
      sh_q <= shifted;
    end
    if (fire) begin
      byte_q <= sh_q[ACC_BITS-1 -: BYTE_BITS];
      last_q <= last;
    end
  end

  assign byte_out_o.valid       = ov_q;
  assign byte_out_o.packed_byte = byte_q;
  assign byte_out_o.last_of_run = last_q;

  assign status_o.busy = busy_q;
  assign status_o.cnt  = cnt_q;

endmodule

// ===== hdl/keypoint_bit_packer.sv =====
// Keypoint bit packer: each keypoint request carries x, y and size in unsigned fixed point
// with four fraction bits; the block rounds each to quarter pixels (half up) and appends
// them MSB first to a byte stream, x in ceil(log2(image_width))+2 bits, y in
// ceil(log2(image_height))+2 bits and size in ten bits, keeping only the low bits of each
// value. Up to seven leftover bits carry over to the next request; a finish request
// emits them as one zero-padded byte and clears them. last_of_run marks the final byte
// that a request produces. A keypoint request completes one to six whole bytes, since even
// the narrowest fields add fourteen bits, and a finish request at most one; the emitter
// sends one byte per cycle while its output register is free or drained by the sink. A
// two-entry queue sits between the front end and the emitter, so requests keep being taken
// while bytes drain, and the output register lets a byte wait for the sink without stalling
// the emitter's next load. Configuration registers (index 0 image_width, index 1
// image_height) are written through cfg_we_i; the user must write them only while the block
// is idle, and the block itself does not enforce this.
module keypoint_bit_packer (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [kbp_pkg::CFG_INDEX_BITS-1:0] cfg_index_i,
  input  logic [kbp_pkg::DIM_BITS-1:0]       cfg_wdata_i,
  kbp_in_if.sink                             kp_in_i,
  kbp_out_if.source                          byte_out_o
);
  import kbp_pkg::*;

  logic                 push;
  kbp_entry_t           push_entry;
  logic                 full;
  kbp_entry_t           pop_entry;
  logic                 pop_valid;
  logic                 pop;
  logic [QCNT_BITS-1:0] q_count;
  kbp_status_t          bk_status;

  // Front end: take requests, round and line up the fields, hold widths
  kbp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .kp_in_i      (kp_in_i),
    .push_o       (push),
    .push_entry_o (push_entry),
    .full_i       (full)
  );

  // Queue: decouple request intake from byte emission
  kbp_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .pop_i        (pop),
    .pop_entry_o  (pop_entry),
    .pop_valid_o  (pop_valid),
    .full_o       (full),
    .count_o      (q_count)
  );

  // Back end: merge with leftover bits, emit bytes, keep the remainder
  kbp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .entry_i       (pop_entry),
    .entry_valid_i (pop_valid),
    .pop_o         (pop),
    .byte_out_o    (byte_out_o),
    .status_o      (bk_status)
  );

`ifndef SYNTHESIS
  // Emitter is only busy with at least one whole byte left
  a_busy_has_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_status.busy |-> (bk_status.cnt >= CNT_BITS'(BYTE_BITS)))
    else $error("emitter busy with less than a byte");

  // Queue never overfills
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_count <= QCNT_BITS'(QUEUE_DEPTH))
    else $error("queue count out of range");

  // Input stalls only when the queue is full
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !kp_in_i.ready |-> (q_count == QCNT_BITS'(QUEUE_DEPTH)))
    else $error("request stalled with queue space free");

  // An empty queue must not pop
  a_no_idle_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_count == '0) |-> !pop)
    else $error("pop from empty queue");
`endif

endmodule
